// ----- hw/rtl/cbb_pkg.sv -----
// ============================================================================
// cbb_pkg - shared constants for the cubic Bezier bounding box unit
// Widths of the scaled coefficients, discriminant, square root and root
// numerators; all follow from the coefficient limit.
// ============================================================================
`default_nettype none

package cbb_pkg;

    localparam int COEF_BITS = 28;
    localparam int COEF_W    = COEF_BITS + 1;
    localparam int DISC_W    = 2 * COEF_BITS + 3;
    localparam int ROOT_W    = COEF_BITS + 2;
    localparam int NUM_W     = COEF_BITS + 3;

endpackage

`default_nettype wire

// ----- hw/rtl/cubic_bezier_tight_bbox_unit.sv -----
// ============================================================================
// cubic_bezier_tight_bbox_unit - tight bounding box of a cubic Bezier curve
// Two identical axis pipelines solve the derivative quadratic, evaluate the
// curve at the roots in [0,1] and merge them with the end points.
//
//   channel | direction | handshake                  | payload
//   request | in        | i_in_valid / o_in_ready    | i_p0_x .. i_p3_y
//   result  | out       | o_out_valid / i_out_ready  | o_x_min .. o_y_max
//
// One request per cycle unless a held result stalls the pipeline; its depth is
// set by the square root (one bit a stage) and the divider (one quotient bit a stage).
// Reset clears only the valid bits of the pipeline.
// A held result stalls the whole pipeline in place; nothing is lost or repeated.
// ============================================================================
`default_nettype none

module cubic_bezier_tight_bbox_unit #(
    parameter int COORD_WIDTH     = 24,
    parameter int PARAM_FRAC_BITS = 20
) (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_in_valid,
    output logic                               o_in_ready,
    input  wire logic signed [COORD_WIDTH-1:0] i_p0_x,
    input  wire logic signed [COORD_WIDTH-1:0] i_p0_y,
    input  wire logic signed [COORD_WIDTH-1:0] i_p1_x,
    input  wire logic signed [COORD_WIDTH-1:0] i_p1_y,
    input  wire logic signed [COORD_WIDTH-1:0] i_p2_x,
    input  wire logic signed [COORD_WIDTH-1:0] i_p2_y,
    input  wire logic signed [COORD_WIDTH-1:0] i_p3_x,
    input  wire logic signed [COORD_WIDTH-1:0] i_p3_y,
    output logic                               o_out_valid,
    input  wire logic                          i_out_ready,
    output logic signed [COORD_WIDTH-1:0]      o_x_min,
    output logic signed [COORD_WIDTH-1:0]      o_x_max,
    output logic signed [COORD_WIDTH-1:0]      o_y_min,
    output logic signed [COORD_WIDTH-1:0]      o_y_max
);

    logic en;
    logic x_v, y_v;

    assign o_out_valid = x_v & y_v;
    assign en          = !o_out_valid || i_out_ready;
    assign o_in_ready  = en;

    cbb_axis #(.CW(COORD_WIDTH), .PF(PARAM_FRAC_BITS)) u_axis_x (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_valid (i_in_valid),
        .i_p0    (i_p0_x),
        .i_p1    (i_p1_x),
        .i_p2    (i_p2_x),
        .i_p3    (i_p3_x),
        .o_valid (x_v),
        .o_lo    (o_x_min),
        .o_hi    (o_x_max)
    );

    cbb_axis #(.CW(COORD_WIDTH), .PF(PARAM_FRAC_BITS)) u_axis_y (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_valid (i_in_valid),
        .i_p0    (i_p0_y),
        .i_p1    (i_p1_y),
        .i_p2    (i_p2_y),
        .i_p3    (i_p3_y),
        .o_valid (y_v),
        .o_lo    (o_y_min),
        .o_hi    (o_y_max)
    );

endmodule

`default_nettype wire

// ----- hw/rtl/cbb_sqrt.sv -----
// ============================================================================
// cbb_sqrt - pipelined integer square root
// One root bit per stage, floor result, with a side payload carried along.
// ============================================================================
`default_nettype none

module cbb_sqrt #(
    parameter int SIDE_W = 1
) (
    input  wire logic                      i_clk,
    input  wire logic                      i_rst_n,
    input  wire logic                      i_en,
    input  wire logic                      i_valid,
    input  wire logic [cbb_pkg::DISC_W-1:0] i_rad,
    input  wire logic [SIDE_W-1:0]         i_side,
    output logic                           o_valid,
    output logic [cbb_pkg::ROOT_W-1:0]     o_root,
    output logic [SIDE_W-1:0]              o_side
);

    localparam int N  = cbb_pkg::ROOT_W;
    localparam int DW = cbb_pkg::DISC_W;

    logic [DW-1:0]     r_rem  [N];
    logic [N-1:0]      r_root [N];
    logic [SIDE_W-1:0] r_side [N];
    logic [N-1:0]      r_vld;

    for (genvar k = 0; k < N; k++) begin : g_stage
        localparam int J = N - 1 - k;
        logic [DW-1:0]     s_rem;
        logic [N-1:0]      s_root;
        logic [SIDE_W-1:0] s_side;
        logic              s_vld;
        logic [DW:0]       trial;
        logic              fits;

        if (k == 0) begin : g_first
            assign s_rem  = i_rad;
            assign s_root = '0;
            assign s_side = i_side;
            assign s_vld  = i_valid;
        end else begin : g_next
            assign s_rem  = r_rem[k-1];
            assign s_root = r_root[k-1];
            assign s_side = r_side[k-1];
            assign s_vld  = r_vld[k-1];
        end

        assign trial = ({{(DW+1-N){1'b0}}, s_root} << (J + 1)) | ((DW+1)'(1) << (2 * J));
        assign fits  = {1'b0, s_rem} >= trial;

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_vld[k] <= 1'b0;
            end else if (i_en) begin
                r_vld[k] <= s_vld;
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_rem[k]  <= fits ? DW'({1'b0, s_rem} - trial) : s_rem;
                r_root[k] <= fits ? (s_root | (N'(1) << J)) : s_root;
                r_side[k] <= s_side;
            end
        end
    end

    assign o_valid = r_vld[N-1];
    assign o_root  = r_root[N-1];
    assign o_side  = r_side[N-1];

endmodule

`default_nettype wire

// ----- hw/rtl/cbb_div.sv -----
// ============================================================================
// cbb_div - pipelined restoring divider for the curve parameter
// Gives floor(num * 2^PF / den) for num <= den, one quotient bit a stage.
// ============================================================================
`default_nettype none

module cbb_div #(
    parameter int PF     = 20,
    parameter int SIDE_W = 1
) (
    input  wire logic                      i_clk,
    input  wire logic                      i_rst_n,
    input  wire logic                      i_en,
    input  wire logic                      i_valid,
    input  wire logic [cbb_pkg::NUM_W-1:0] i_num,
    input  wire logic [cbb_pkg::NUM_W-1:0] i_den,
    input  wire logic [SIDE_W-1:0]         i_side,
    output logic                           o_valid,
    output logic [PF:0]                    o_quot,
    output logic [SIDE_W-1:0]              o_side
);

    localparam int NW = cbb_pkg::NUM_W;

    logic [NW-1:0]     r_rem  [PF+1];
    logic [NW-1:0]     r_den  [PF+1];
    logic [PF:0]       r_q    [PF+1];
    logic [SIDE_W-1:0] r_side [PF+1];
    logic [PF:0]       r_vld;

    for (genvar k = 0; k <= PF; k++) begin : g_stage
        logic [NW-1:0]     n_rem;
        logic [PF:0]       n_q;
        logic [NW-1:0]     s_den;
        logic [SIDE_W-1:0] s_side;
        logic              s_vld;

        if (k == 0) begin : g_first
            logic top;
            assign top    = (i_num == i_den);
            assign n_rem  = top ? '0 : i_num;
            assign n_q    = {{PF{1'b0}}, top};
            assign s_den  = i_den;
            assign s_side = i_side;
            assign s_vld  = i_valid;
        end else begin : g_next
            logic [NW:0] rem2;
            logic        ge;
            assign rem2   = {r_rem[k-1], 1'b0};
            assign ge     = rem2 >= {1'b0, r_den[k-1]};
            assign n_rem  = ge ? NW'(rem2 - {1'b0, r_den[k-1]}) : rem2[NW-1:0];
            assign n_q    = {r_q[k-1][PF-1:0], ge};
            assign s_den  = r_den[k-1];
            assign s_side = r_side[k-1];
            assign s_vld  = r_vld[k-1];
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_vld[k] <= 1'b0;
            end else if (i_en) begin
                r_vld[k] <= s_vld;
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_rem[k]  <= n_rem;
                r_q[k]    <= n_q;
                r_den[k]  <= s_den;
                r_side[k] <= s_side;
            end
        end
    end

    assign o_valid = r_vld[PF];
    assign o_quot  = r_q[PF];
    assign o_side  = r_side[PF];

endmodule

`default_nettype wire

// ----- hw/rtl/cbb_eval.sv -----
// ============================================================================
// cbb_eval - pipelined de Casteljau evaluation of one cubic at parameter t
// Three blend levels, each a multiply stage and an add stage.
// ============================================================================
`default_nettype none

module cbb_eval #(
    parameter int CW     = 24,
    parameter int PF     = 20,
    parameter int SIDE_W = 1
) (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 i_en,
    input  wire logic                 i_valid,
    input  wire logic signed [CW-1:0] i_p0,
    input  wire logic signed [CW-1:0] i_p1,
    input  wire logic signed [CW-1:0] i_p2,
    input  wire logic signed [CW-1:0] i_p3,
    input  wire logic [PF:0]          i_t,
    input  wire logic [SIDE_W-1:0]    i_side,
    output logic                      o_valid,
    output logic signed [CW-1:0]      o_value,
    output logic [SIDE_W-1:0]         o_side
);

    localparam int PW = CW + PF + 3;
    localparam int NS = 6;

    function automatic logic signed [PW-1:0] f_mul(input logic signed [CW-1:0] p,
                                                    input logic signed [CW-1:0] q,
                                                    input logic [PF:0] t);
        logic signed [CW:0]   d;
        logic signed [PF+1:0] ts;
        d  = q - p;
        ts = {1'b0, t};
        return d * ts;
    endfunction

    function automatic logic signed [CW-1:0] f_add(input logic signed [CW-1:0] p,
                                                    input logic signed [PW-1:0] prod);
        logic signed [PW-1:0] sh;
        sh = prod >>> PF;
        return p + sh[CW-1:0];
    endfunction

    logic signed [PW-1:0] r1_prod [3];
    logic signed [CW-1:0] r1_base [3];
    logic [PF:0]          r1_t;
    logic signed [CW-1:0] r2_q [3];
    logic [PF:0]          r2_t;
    logic signed [PW-1:0] r3_prod [2];
    logic signed [CW-1:0] r3_base [2];
    logic [PF:0]          r3_t;
    logic signed [CW-1:0] r4_r [2];
    logic [PF:0]          r4_t;
    logic signed [PW-1:0] r5_prod;
    logic signed [CW-1:0] r5_base;
    logic signed [CW-1:0] r6_v;
    logic [SIDE_W-1:0]    r_side [NS];
    logic [NS-1:0]        r_vld;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (i_en) begin
            r_vld <= {r_vld[NS-2:0], i_valid};
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r1_prod[0] <= f_mul(i_p0, i_p1, i_t);
            r1_prod[1] <= f_mul(i_p1, i_p2, i_t);
            r1_prod[2] <= f_mul(i_p2, i_p3, i_t);
            r1_base[0] <= i_p0;
            r1_base[1] <= i_p1;
            r1_base[2] <= i_p2;
            r1_t       <= i_t;
            for (int k = 0; k < 3; k++) begin
                r2_q[k] <= f_add(r1_base[k], r1_prod[k]);
            end
            r2_t       <= r1_t;
            r3_prod[0] <= f_mul(r2_q[0], r2_q[1], r2_t);
            r3_prod[1] <= f_mul(r2_q[1], r2_q[2], r2_t);
            r3_base[0] <= r2_q[0];
            r3_base[1] <= r2_q[1];
            r3_t       <= r2_t;
            r4_r[0]    <= f_add(r3_base[0], r3_prod[0]);
            r4_r[1]    <= f_add(r3_base[1], r3_prod[1]);
            r4_t       <= r3_t;
            r5_prod    <= f_mul(r4_r[0], r4_r[1], r4_t);
            r5_base    <= r4_r[0];
            r6_v       <= f_add(r5_base, r5_prod);
            r_side[0]  <= i_side;
            for (int k = 1; k < NS; k++) begin
                r_side[k] <= r_side[k-1];
            end
        end
    end

    assign o_valid = r_vld[NS-1];
    assign o_value = r6_v;
    assign o_side  = r_side[NS-1];

endmodule

`default_nettype wire

// ----- hw/rtl/cbb_axis.sv -----
// ============================================================================
// cbb_axis - bounds of one axis of a cubic Bezier curve
// Coefficients, scaling, discriminant, square root, root division,
// evaluation at both roots and the final min/max, all pipelined.
// ============================================================================
`default_nettype none

module cbb_axis #(
    parameter int CW = 24,
    parameter int PF = 20
) (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 i_en,
    input  wire logic                 i_valid,
    input  wire logic signed [CW-1:0] i_p0,
    input  wire logic signed [CW-1:0] i_p1,
    input  wire logic signed [CW-1:0] i_p2,
    input  wire logic signed [CW-1:0] i_p3,
    output logic                      o_valid,
    output logic signed [CW-1:0]      o_lo,
    output logic signed [CW-1:0]      o_hi
);

    localparam int KW  = CW + 5;
    localparam int CO  = cbb_pkg::COEF_W;
    localparam int CB  = cbb_pkg::COEF_BITS;
    localparam int XW  = (KW > CO) ? KW : CO;
    localparam int SW  = $clog2(KW + 1);
    localparam int EW  = 2 * CO + 3;
    localparam int DW  = cbb_pkg::DISC_W;
    localparam int RW  = cbb_pkg::ROOT_W;
    localparam int NW  = cbb_pkg::NUM_W;
    localparam int SQ_W = 6 * CW + 2 * CO + 1;
    localparam int D1_W = 6 * CW + 1;
    localparam int E1_W = 2 * CW + 1;

    function automatic logic [KW-1:0] f_mag(input logic signed [KW-1:0] v);
        return v[KW-1] ? KW'(-v) : v;
    endfunction

    // stage 1: power-basis coefficients
    logic signed [KW-1:0] e0, e1, e2, e3, n1_a, n1_b, n1_c;
    logic signed [KW-1:0] r1_a, r1_b, r1_c;
    logic signed [CW-1:0] r1_p [4];
    logic signed [CW-1:0] r1_lo, r1_hi;
    logic                 r1_v;

    assign e0 = i_p0;
    assign e1 = i_p1;
    assign e2 = i_p2;
    assign e3 = i_p3;
    assign n1_a = e3 - (e2 <<< 1) - e2 + (e1 <<< 1) + e1 - e0;
    assign n1_b = (e2 <<< 1) + e2 - (e1 <<< 2) - (e1 <<< 1) + (e0 <<< 1) + e0;
    assign n1_c = (e1 <<< 1) + e1 - (e0 <<< 1) - e0;

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r1_a    <= n1_a;
            r1_b    <= n1_b;
            r1_c    <= n1_c;
            r1_p[0] <= i_p0;
            r1_p[1] <= i_p1;
            r1_p[2] <= i_p2;
            r1_p[3] <= i_p3;
            r1_lo   <= (i_p0 < i_p3) ? i_p0 : i_p3;
            r1_hi   <= (i_p0 < i_p3) ? i_p3 : i_p0;
        end
    end

    // stage 2: scale coefficients below the limit
    logic [KW-1:0]        m;
    logic [SW-1:0]        s;
    logic signed [XW-1:0] ta, tb, tc;
    logic signed [CO-1:0] r2_a, r2_b, r2_c;
    logic signed [CW-1:0] r2_p [4];
    logic signed [CW-1:0] r2_lo, r2_hi;
    logic                 r2_v;

    assign m = f_mag(r1_a) | f_mag(r1_b) | f_mag(r1_c);

    always_comb begin
        s = '0;
        for (int k = CB; k < KW; k++) begin
            if (m[k]) begin
                s = SW'(k - CB + 1);
            end
        end
    end

    assign ta = r1_a >>> s;
    assign tb = r1_b >>> s;
    assign tc = r1_c >>> s;

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r2_a  <= ta[CO-1:0];
            r2_b  <= tb[CO-1:0];
            r2_c  <= tc[CO-1:0];
            r2_p  <= r1_p;
            r2_lo <= r1_lo;
            r2_hi <= r1_hi;
        end
    end

    // stage 3: products
    logic signed [2*CO-1:0] r3_bb, r3_ac;
    logic signed [CO-1:0]   r3_a, r3_b;
    logic                   r3_az;
    logic signed [CW-1:0]   r3_p [4];
    logic signed [CW-1:0]   r3_lo, r3_hi;
    logic                   r3_v;

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r3_bb <= r2_b * r2_b;
            r3_ac <= r2_a * r2_c;
            r3_a  <= r2_a;
            r3_b  <= r2_b;
            r3_az <= (r2_a == '0);
            r3_p  <= r2_p;
            r3_lo <= r2_lo;
            r3_hi <= r2_hi;
        end
    end

    // stage 4: discriminant
    logic signed [EW-1:0] ebb, eac, disc;
    logic                 noext;
    logic [DW-1:0]        r4_rad;
    logic [SQ_W-1:0]      r4_side;
    logic                 r4_v;

    assign ebb   = r3_bb;
    assign eac   = r3_ac;
    assign disc  = ebb - (eac <<< 1) - eac;
    assign noext = r3_az | disc[EW-1];

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r4_rad  <= noext ? '0 : disc[DW-1:0];
            r4_side <= {r3_p[0], r3_p[1], r3_p[2], r3_p[3], r3_lo, r3_hi,
                        r3_a, r3_b, noext};
        end
    end

    // square root
    logic            sq_v;
    logic [RW-1:0]   sq_root;
    logic [SQ_W-1:0] sq_side;

    cbb_sqrt #(.SIDE_W(SQ_W)) u_sqrt (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (i_en),
        .i_valid (r4_v),
        .i_rad   (r4_rad),
        .i_side  (r4_side),
        .o_valid (sq_v),
        .o_root  (sq_root),
        .o_side  (sq_side)
    );

    // stage 5: root numerators and denominator
    logic signed [CW-1:0] sq_p0, sq_p1, sq_p2, sq_p3, sq_lo, sq_hi;
    logic signed [CO-1:0] sq_a, sq_b;
    logic                 sq_noext;
    logic signed [NW-1:0] eb, ea, er, num1, num2, den, n1, n2, nd;
    logic                 keep1, keep2;
    logic [NW-1:0]        r5_num1, r5_num2, r5_den;
    logic [D1_W-1:0]      r5_side;
    logic                 r5_keep2;
    logic                 r5_v;

    assign {sq_p0, sq_p1, sq_p2, sq_p3, sq_lo, sq_hi, sq_a, sq_b, sq_noext} = sq_side;
    assign eb   = sq_b;
    assign ea   = sq_a;
    assign er   = {{(NW-RW){1'b0}}, sq_root};
    assign num1 = er - eb;
    assign num2 = -eb - er;
    assign den  = (ea <<< 1) + ea;
    assign n1   = den[NW-1] ? -num1 : num1;
    assign n2   = den[NW-1] ? -num2 : num2;
    assign nd   = den[NW-1] ? -den : den;
    assign keep1 = !sq_noext && !n1[NW-1] && (n1 <= nd);
    assign keep2 = !sq_noext && !n2[NW-1] && (n2 <= nd);

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r5_num1  <= n1;
            r5_num2  <= n2;
            r5_den   <= nd;
            r5_side  <= {sq_p0, sq_p1, sq_p2, sq_p3, sq_lo, sq_hi, keep1};
            r5_keep2 <= keep2;
        end
    end

    // parameter division
    logic            d1_v, d2_v;
    logic [PF:0]     d1_t, d2_t;
    logic [D1_W-1:0] d1_side;
    logic            d2_keep;

    cbb_div #(.PF(PF), .SIDE_W(D1_W)) u_div1 (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (i_en),
        .i_valid (r5_v),
        .i_num   (r5_num1),
        .i_den   (r5_den),
        .i_side  (r5_side),
        .o_valid (d1_v),
        .o_quot  (d1_t),
        .o_side  (d1_side)
    );

    cbb_div #(.PF(PF), .SIDE_W(1)) u_div2 (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (i_en),
        .i_valid (r5_v),
        .i_num   (r5_num2),
        .i_den   (r5_den),
        .i_side  (r5_keep2),
        .o_valid (d2_v),
        .o_quot  (d2_t),
        .o_side  (d2_keep)
    );

    // curve evaluation at both roots
    logic signed [CW-1:0] d_p0, d_p1, d_p2, d_p3, d_lo, d_hi;
    logic                 d_keep1;
    logic                 v1_v, v2_v;
    logic signed [CW-1:0] v1, v2;
    logic [E1_W-1:0]      v1_side;
    logic                 v2_keep;

    assign {d_p0, d_p1, d_p2, d_p3, d_lo, d_hi, d_keep1} = d1_side;

    cbb_eval #(.CW(CW), .PF(PF), .SIDE_W(E1_W)) u_eval1 (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (i_en),
        .i_valid (d1_v),
        .i_p0    (d_p0),
        .i_p1    (d_p1),
        .i_p2    (d_p2),
        .i_p3    (d_p3),
        .i_t     (d1_t),
        .i_side  ({d_lo, d_hi, d_keep1}),
        .o_valid (v1_v),
        .o_value (v1),
        .o_side  (v1_side)
    );

    cbb_eval #(.CW(CW), .PF(PF), .SIDE_W(1)) u_eval2 (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (i_en),
        .i_valid (d2_v),
        .i_p0    (d_p0),
        .i_p1    (d_p1),
        .i_p2    (d_p2),
        .i_p3    (d_p3),
        .i_t     (d2_t),
        .i_side  (d2_keep),
        .o_valid (v2_v),
        .o_value (v2),
        .o_side  (v2_keep)
    );

    // final stage: merge extrema into the end-point box
    logic signed [CW-1:0] f_lo, f_hi, lo1, hi1, lo2, hi2;
    logic                 f_keep1;
    logic signed [CW-1:0] r_lo, r_hi;
    logic                 r_v;

    assign {f_lo, f_hi, f_keep1} = v1_side;
    assign lo1 = (f_keep1 && (v1 < f_lo)) ? v1 : f_lo;
    assign hi1 = (f_keep1 && (v1 > f_hi)) ? v1 : f_hi;
    assign lo2 = (v2_keep && (v2 < lo1)) ? v2 : lo1;
    assign hi2 = (v2_keep && (v2 > hi1)) ? v2 : hi1;

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_lo <= lo2;
            r_hi <= hi2;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_v <= 1'b0;
            r2_v <= 1'b0;
            r3_v <= 1'b0;
            r4_v <= 1'b0;
            r5_v <= 1'b0;
            r_v  <= 1'b0;
        end else if (i_en) begin
            r1_v <= i_valid;
            r2_v <= r1_v;
            r3_v <= r2_v;
            r4_v <= r3_v;
            r5_v <= sq_v;
            r_v  <= v1_v & v2_v;
        end
    end

    assign o_valid = r_v;
    assign o_lo    = r_lo;
    assign o_hi    = r_hi;

endmodule

`default_nettype wire

// ----- sim/cubic_bezier_tight_bbox_unit_tb.sv -----
`timescale 1ns / 1ps
// ============================================================================
// cubic_bezier_tight_bbox_unit_tb - self-checking bench for the bbox unit
// Drives curves through the valid/ready request channel with random idling.
// A scoreboard works out each curve's tight box in software and compares every
// result with the oldest expected box.
// ============================================================================

class bbox_scoreboard;
    typedef struct {
        logic signed [23:0] x_min, x_max, y_min, y_max;
    } t_box;

    t_box       pending_boxes[$];
    int         errors;

    function longint shift_down(longint v, int s);
        return v >>> s;
    endfunction

    function longint int_sqrt(longint n);
        longint r, lo, hi, mid;
        lo = 0; hi = 64'd3037000499;
        while (lo < hi) begin
            mid = (lo + hi + 1) / 2;
            if (mid * mid <= n) lo = mid; else hi = mid - 1;
        end
        r = lo;
        return r;
    endfunction

    function longint scale_by_t(longint d, longint t);
        longint hi, lo;
        hi = d >>> 20;
        lo = d - (hi <<< 20);
        return hi * t + ((lo * t) >>> 20);
    endfunction

    function longint lerp(longint p, longint q, longint t);
        return p + scale_by_t(q - p, t);
    endfunction

    function longint point_on_curve(longint p0, p1, p2, p3, longint t);
        longint q0, q1, q2, r0, r1;
        q0 = lerp(p0, p1, t); q1 = lerp(p1, p2, t); q2 = lerp(p2, p3, t);
        r0 = lerp(q0, q1, t); r1 = lerp(q1, q2, t);
        return lerp(r0, r1, t);
    endfunction

    function void axis_span(longint p0, p1, p2, p3, output longint lo, output longint hi);
        longint a, b, c, m, disc, rt, num, den, t, v;
        int s;
        a = p3 - 3*p2 + 3*p1 - p0;
        b = 3*p2 - 6*p1 + 3*p0;
        c = 3*p1 - 3*p0;
        lo = p0 < p3 ? p0 : p3;
        hi = p0 < p3 ? p3 : p0;
        m = (a < 0 ? -a : a) | (b < 0 ? -b : b) | (c < 0 ? -c : c);
        s = 0;
        while ((m >>> s) >= (64'sd1 <<< 28)) s++;
        a = shift_down(a, s); b = shift_down(b, s); c = shift_down(c, s);
        if (a == 0) return;
        disc = b*b - 3*a*c;
        if (disc < 0) return;
        rt = int_sqrt(disc);
        for (int k = 0; k < 2; k++) begin
            num = k ? (-b - rt) : (-b + rt);
            den = 3*a;
            if (den < 0) begin
                den = -den; num = -num;
            end
            if (num < 0 || num > den) continue;
            t = (num <<< 20) / den;
            v = point_on_curve(p0, p1, p2, p3, t);
            if (v < lo) lo = v;
            if (v > hi) hi = v;
        end
    endfunction

    function void note_request(logic signed [23:0] p[8]);
        longint lo, hi;
        t_box b;
        axis_span(p[0], p[2], p[4], p[6], lo, hi);
        b.x_min = lo[23:0]; b.x_max = hi[23:0];
        axis_span(p[1], p[3], p[5], p[7], lo, hi);
        b.y_min = lo[23:0]; b.y_max = hi[23:0];
        pending_boxes.insert(pending_boxes.size(), b);
    endfunction

    function void check_box(logic signed [23:0] xn, xx, yn, yx);
        t_box e;
        if (pending_boxes.size() == 0) begin
            $display("%0t: result with none expected: %0d %0d %0d %0d", $time, xn, xx, yn, yx);
            errors++;
            return;
        end
        e = pending_boxes.pop_front();
        if (xn !== e.x_min) begin
            $display("%0t: x_min expected %0d actual %0d", $time, e.x_min, xn); errors++;
        end
        if (xx !== e.x_max) begin
            $display("%0t: x_max expected %0d actual %0d", $time, e.x_max, xx); errors++;
        end
        if (yn !== e.y_min) begin
            $display("%0t: y_min expected %0d actual %0d", $time, e.y_min, yn); errors++;
        end
        if (yx !== e.y_max) begin
            $display("%0t: y_max expected %0d actual %0d", $time, e.y_max, yx); errors++;
        end
    endfunction
endclass

module cubic_bezier_tight_bbox_unit_tb;
    localparam int LATENCY = 63;
    localparam longint CYCLE_LIMIT = 400000;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic i_in_valid = 1'b0;
    logic i_out_ready = 1'b0;
    logic signed [23:0] pts[8];
    logic o_in_ready, o_out_valid;
    logic signed [23:0] o_x_min, o_x_max, o_y_min, o_y_max;

    bbox_scoreboard board = new();
    longint cycles = 0;
    bit calm = 1'b0;
    bit hold_off = 1'b0;

    initial foreach (pts[i]) pts[i] = '0;

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    cubic_bezier_tight_bbox_unit dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_in_valid(i_in_valid), .o_in_ready(o_in_ready),
        .i_p0_x(pts[0]), .i_p0_y(pts[1]), .i_p1_x(pts[2]), .i_p1_y(pts[3]),
        .i_p2_x(pts[4]), .i_p2_y(pts[5]), .i_p3_x(pts[6]), .i_p3_y(pts[7]),
        .o_out_valid(o_out_valid), .i_out_ready(i_out_ready),
        .o_x_min(o_x_min), .o_x_max(o_x_max), .o_y_min(o_y_min), .o_y_max(o_y_max)
    );

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("Some tests failed");
            $finish;
        end
    end

    // result side: random stalls, plus a hold-off when asked
    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && i_out_ready)
            board.check_box(o_x_min, o_x_max, o_y_min, o_y_max);
        if (hold_off)
            i_out_ready <= 1'b0;
        else
            i_out_ready <= calm ? 1'b1 : ($urandom_range(99) >= 17);
    end

    // hold off the result side long enough to fill the pipeline
    initial begin
        repeat (900) @(posedge i_clk);
        hold_off <= 1'b1;
        repeat (200) @(posedge i_clk);
        hold_off <= 1'b0;
    end

    task automatic send_curve(input logic signed [23:0] c[8]);
        while (!calm && $urandom_range(99) < 17) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        foreach (pts[i]) pts[i] <= c[i];
        do @(posedge i_clk); while (!o_in_ready);
        board.note_request(c);
    endtask

    function automatic logic signed [23:0] pick_coord(int kind);
        case (kind)
            0: return 24'sh7fffff;
            1: return 24'sh800000;
            2: return $signed(24'($urandom_range(2047))) - 24'sd1024;
            default: return 24'($urandom);
        endcase
    endfunction

    task automatic wait_drained();
        while (board.pending_boxes.size() != 0) @(posedge i_clk);
    endtask

    initial begin
        logic signed [23:0] c[8];
        int kind;
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        // directed: extremes, flat, straight line, loop, exact end roots
        for (int d = 0; d < 20; d++) begin
            foreach (c[i]) begin
                case (d)
                    0: c[i] = 24'sh7fffff;
                    1: c[i] = 24'sh800000;
                    2: c[i] = '0;
                    3: c[i] = (i < 2) ? 24'sh800000 : 24'sh7fffff;
                    4: c[i] = (i == 2 || i == 3 || i == 4 || i == 5) ? 24'sh7fffff : 24'sh800000;
                    5: c[i] = (i == 2 || i == 5) ? 24'sh7fffff
                            : ((i == 3 || i == 4) ? 24'sh800000 : 24'sd0);
                    6: c[i] = 24'(100 * (i / 2));
                    7: c[i] = (i == 2 || i == 3) ? 24'sd300
                            : ((i == 4 || i == 5) ? -24'sd300 : 24'sd0);
                    8: c[i] = (i / 2 == 1 || i / 2 == 2) ? 24'sd256 : 24'sd0;
                    9: c[i] = (i / 2 == 3) ? 24'sd3 : 24'sd0;
                    default: c[i] = pick_coord(d % 4);
                endcase
            end
            send_curve(c);
        end
        i_in_valid <= 1'b0;
        // pause until every result is back
        wait_drained();
        for (int n = 0; n < 1400; n++) begin
            calm = (n >= 600 && n < 800);
            kind = $urandom_range(9);
            foreach (c[i])
                c[i] = (kind < 6) ? pick_coord(2 + (kind & 1)) : pick_coord($urandom_range(3));
            send_curve(c);
        end
        i_in_valid <= 1'b0;
        wait_drained();
        repeat (LATENCY + 10) @(posedge i_clk);
        if (board.errors == 0 && board.pending_boxes.size() == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end
endmodule

// ----- cubic_bezier_tight_bbox_unit.f -----
hw/rtl/cbb_pkg.sv
hw/rtl/cbb_sqrt.sv
hw/rtl/cbb_div.sv
hw/rtl/cbb_eval.sv
hw/rtl/cbb_axis.sv
hw/rtl/cubic_bezier_tight_bbox_unit.sv
sim/cubic_bezier_tight_bbox_unit_tb.sv
